// ----- design/dctb_pkg.sv -----
`timescale 1ns / 1ps
package dctb_pkg;

	localparam int MASK_W    = 16;
	localparam int COUNT_W   = 32;
	localparam int TIME_W    = 32;
	localparam int DT_W      = 24;
	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 24;
	localparam int M_PAD_W   = M_TDATA_W - MASK_W - 1;

	localparam logic OP_ARM  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               wr;
		logic               fire;
		logic [COUNT_W-1:0] next;
	} slot_upd_t;

endpackage

// ----- design/delta_countdown_timer_bank.sv -----
`timescale 1ns / 1ps
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   tuser: opcode; tdata: event_mask, count_value, now_time
// m_*      out  m_tvalid/m_tready   tdata: fired_mask, arm_ignored, zero pad
//
// an arm or a tick at the stored time is finished in the setup state, with no slot walk
// a tick that moves the time walks the counter ram slot by slot, reading every slot and
// writing back the armed ones through a single shared subtract/compare unit
// after reset all slots read as disarmed through per-slot valid bits, no clearing pass
// a result waits in the output register while the next item is taken; a block finishing
// while that register is still full holds in its done state until m_tready
module delta_countdown_timer_bank #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [dctb_pkg::S_TDATA_W-1:0] s_tdata,  // event_mask, count_value, now_time
	input  logic                           s_tuser,  // opcode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [dctb_pkg::M_TDATA_W-1:0] m_tdata   // fired_mask, arm_ignored, zero pad
);
	import dctb_pkg::*;

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = IDX_W + 1;
	localparam logic [MASK_W-1:0] SLOT_MASK = MASK_W'((33'd1 << NUM_SLOTS) - 33'd1);
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_SLOTS - 1);
	localparam logic [CNT_W-1:0]  NUM_CNT   = CNT_W'(NUM_SLOTS);

	state_t state_q, state_d;

	logic               op_q;
	logic [MASK_W-1:0]  mask_q;
	logic [COUNT_W-1:0] count_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  last_time_q;
	logic [DT_W-1:0]    dt_q;
	logic [NUM_SLOTS-1:0] vld_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic [IDX_W-1:0]   idx_s1;
	logic [MASK_W-1:0]  fired_q;
	logic [MASK_W-1:0]  res_fired_q;
	logic               res_ign_q;
	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic               arm_ok;
	logic [IDX_W-1:0]   arm_idx;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [COUNT_W-1:0] ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [COUNT_W-1:0] ram_rdata;
	logic [COUNT_W-1:0] slot_cur;
	slot_upd_t          upd;
	logic [MASK_W-1:0]  fired_now;
	logic               finish;
	logic [MASK_W-1:0]  fin_fired;
	logic               fin_ign;
	logic               out_free;
	logic               out_load;
	logic [MASK_W-1:0]  out_fired;
	logic               out_ign;

	dctb_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(NUM_SLOTS)
	) u_count_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// a slot never written since reset reads as disarmed
	assign slot_cur = vld_q[idx_s1] ? ram_rdata : '0;

	dctb_slot_alu u_slot_alu (
		.cur(slot_cur),
		.dt (dt_q),
		.upd(upd)
	);

	assign fired_now = fired_q | (upd.fire ? (MASK_W'(1) << idx_s1) : '0);
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		arm_ok  = ((mask_q & ~SLOT_MASK) == '0) && $onehot(mask_q);
		arm_idx = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (mask_q[i]) begin
				arm_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		finish    = 1'b0;
		fin_fired = '0;
		fin_ign   = 1'b0;
		out_load  = 1'b0;
		out_fired = res_fired_q;
		out_ign   = res_ign_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				if (op_q == OP_ARM) begin
					ram_we    = arm_ok;
					ram_waddr = arm_idx;
					ram_wdata = count_q;
					finish    = 1'b1;
					fin_ign   = !arm_ok;
				end else if (now_q == last_time_q) begin
					finish = 1'b1;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = '0;
					state_d   = ST_WALK;
				end
			end
			ST_WALK: begin
				// read of the next slot overlaps the write back of the current one
				ram_re    = rd_idx_q < NUM_CNT;
				ram_raddr = rd_idx_q[IDX_W-1:0];
				ram_we    = upd.wr;
				ram_waddr = idx_s1;
				ram_wdata = upd.next;
				if (idx_s1 == LAST_IDX) begin
					finish    = 1'b1;
					fin_fired = fired_now;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (finish) begin
			if (out_free) begin
				out_load  = 1'b1;
				out_fired = fin_fired;
				out_ign   = fin_ign;
				state_d   = ST_IDLE;
			end else begin
				state_d = ST_DONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q    <= s_tuser;
			mask_q  <= s_tdata[MASK_W-1:0];
			count_q <= s_tdata[MASK_W+COUNT_W-1:MASK_W];
			now_q   <= s_tdata[MASK_W+COUNT_W+TIME_W-1:MASK_W+COUNT_W];
		end
		if (state_q == ST_SETUP) begin
			dt_q <= DT_W'(now_q - last_time_q);
		end
		if (finish && !out_free) begin
			res_fired_q <= fin_fired;
			res_ign_q   <= fin_ign;
		end
		if (out_load) begin
			m_tdata_q <= {{M_PAD_W{1'b0}}, out_ign, out_fired};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			vld_q       <= '0;
			rd_idx_q    <= '0;
			idx_s1      <= '0;
			fired_q     <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (state_q == ST_SETUP && state_d == ST_WALK) begin
				last_time_q <= now_q;
				rd_idx_q    <= CNT_W'(1);
				idx_s1      <= '0;
				fired_q     <= '0;
			end
			if (state_q == ST_WALK) begin
				idx_s1  <= rd_idx_q[IDX_W-1:0];
				fired_q <= fired_now;
				if (ram_re) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("counter ram read and write hit the same slot");

	a_arm_no_fire: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[MASK_W] |-> m_tdata[MASK_W-1:0] == '0)
		else $error("ignored arm reports fired slots");

	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SETUP && op_q == OP_TICK && now_q != last_time_q
		|=> state_q == ST_WALK && idx_s1 == '0)
		else $error("time step did not start the slot walk at slot zero");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("result lost on its way to the output register");

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_SETUP)
		else $error("transfer taken without entering setup");

endmodule

// ----- design/dctb_ram.sv -----
`timescale 1ns / 1ps
module dctb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/dctb_slot_alu.sv -----
`timescale 1ns / 1ps
module dctb_slot_alu (
	input  logic [dctb_pkg::COUNT_W-1:0] cur,
	input  logic [dctb_pkg::DT_W-1:0]    dt,
	output dctb_pkg::slot_upd_t          upd
);
	import dctb_pkg::*;

	logic [COUNT_W-1:0] dt_ext;
	logic               armed;
	logic               expire;

	assign dt_ext = COUNT_W'(dt);

	always_comb begin
		armed    = cur != '0;
		// reaching zero or going below it both count as expiry
		expire   = armed && (cur <= dt_ext);
		upd.wr   = armed;
		upd.fire = expire;
		upd.next = expire ? '0 : cur - dt_ext;
	end

endmodule
